FILE: rtl/core/quaternion_aabb_rotate_top_macros.svh
// ----------------------------------------------------------------------------
// Quaternion AABB rotate assertion macros
// Shared assertion wrappers for the rotated-box datapath.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_AABB_ROTATE_TOP_MACROS_SVH
`define QUATERNION_AABB_ROTATE_TOP_MACROS_SVH

// same-cycle implication
`define QAR_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define QAR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/qar_pkg.sv
// ----------------------------------------------------------------------------
// Quaternion AABB rotate package
// Widths, payload types, register indexes and fixed-point helpers.
// ----------------------------------------------------------------------------
package qar_pkg;

  localparam int unsigned COORD_BITS     = 32;
  localparam int unsigned QUAT_FRAC_BITS = 16;
  localparam int unsigned QUAT_BITS      = QUAT_FRAC_BITS + 2;
  localparam int unsigned NUM_CORNERS    = 8;
  localparam int unsigned NUM_AXES       = 3;

  // q * coordinate
  localparam int unsigned P1_W = QUAT_BITS + COORD_BITS;
  localparam int unsigned M1_W = P1_W - QUAT_FRAC_BITS;
  // first cross product
  localparam int unsigned U_W  = M1_W + 1;
  // q * u
  localparam int unsigned P2_W = QUAT_BITS + U_W;
  localparam int unsigned M2_W = P2_W - QUAT_FRAC_BITS;
  localparam int unsigned T_W  = M2_W + 1;
  localparam int unsigned R_W  = M2_W + 5;

  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_QUAT_W = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_QUAT_X = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_QUAT_Y = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_QUAT_Z = CFG_IDX_W'(3);

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic signed [P1_W-1:0] HALF1 = P1_W'(1) << (QUAT_FRAC_BITS - 1);
  localparam logic signed [P2_W-1:0] HALF2 = P2_W'(1) << (QUAT_FRAC_BITS - 1);
  localparam logic signed [R_W-1:0] SAT_HI =
    {{(R_W - COORD_BITS + 1){1'b0}}, {(COORD_BITS - 1){1'b1}}};
  localparam logic signed [R_W-1:0] SAT_LO =
    {{(R_W - COORD_BITS + 1){1'b1}}, {(COORD_BITS - 1){1'b0}}};

  typedef struct packed {
    logic signed [QUAT_BITS-1:0] w;
    logic signed [QUAT_BITS-1:0] x;
    logic signed [QUAT_BITS-1:0] y;
    logic signed [QUAT_BITS-1:0] z;
  } quat_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] in_min_x;
    logic signed [COORD_BITS-1:0] in_min_y;
    logic signed [COORD_BITS-1:0] in_min_z;
    logic signed [COORD_BITS-1:0] in_max_x;
    logic signed [COORD_BITS-1:0] in_max_y;
    logic signed [COORD_BITS-1:0] in_max_z;
    logic                         in_box_valid;
  } in_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] out_min_x;
    logic signed [COORD_BITS-1:0] out_min_y;
    logic signed [COORD_BITS-1:0] out_min_z;
    logic signed [COORD_BITS-1:0] out_max_x;
    logic signed [COORD_BITS-1:0] out_max_y;
    logic signed [COORD_BITS-1:0] out_max_z;
    logic                         out_box_valid;
  } out_t;

  // per-coordinate products, index 0 = min corner value, 1 = max
  typedef struct packed {
    logic [NUM_AXES-1:0][COORD_BITS-1:0] lo;
    logic [NUM_AXES-1:0][COORD_BITS-1:0] hi;
    logic [1:0][M1_W-1:0] m_yz;
    logic [1:0][M1_W-1:0] m_zy;
    logic [1:0][M1_W-1:0] m_zx;
    logic [1:0][M1_W-1:0] m_xz;
    logic [1:0][M1_W-1:0] m_xy;
    logic [1:0][M1_W-1:0] m_yx;
    logic box_valid;
  } mid_t;

  function automatic logic signed [M1_W-1:0] mulq1(input logic signed [QUAT_BITS-1:0] q,
                                                  input logic signed [COORD_BITS-1:0] v);
    logic signed [P1_W-1:0] prod;
    prod = P1_W'(q) * P1_W'(v);
    prod = prod + HALF1;
    return prod[P1_W-1:QUAT_FRAC_BITS];
  endfunction

  function automatic logic signed [M2_W-1:0] mulq2(input logic signed [QUAT_BITS-1:0] q,
                                                  input logic signed [U_W-1:0] v);
    logic signed [P2_W-1:0] prod;
    prod = P2_W'(q) * P2_W'(v);
    prod = prod + HALF2;
    return prod[P2_W-1:QUAT_FRAC_BITS];
  endfunction

  function automatic logic signed [COORD_BITS-1:0] sat_coord(input logic signed [R_W-1:0] r);
    logic signed [R_W-1:0] s;
    s = r;
    if (r > SAT_HI) begin
      s = SAT_HI;
    end else if (r < SAT_LO) begin
      s = SAT_LO;
    end
    return s[COORD_BITS-1:0];
  endfunction

  function automatic logic signed [COORD_BITS-1:0] min2(input logic signed [COORD_BITS-1:0] a,
                                                       input logic signed [COORD_BITS-1:0] b);
    return (b < a) ? b : a;
  endfunction

  function automatic logic signed [COORD_BITS-1:0] max2(input logic signed [COORD_BITS-1:0] a,
                                                       input logic signed [COORD_BITS-1:0] b);
    return (b > a) ? b : a;
  endfunction

endpackage

FILE: rtl/core/qar_front.sv
// ----------------------------------------------------------------------------
// Quaternion AABB rotate front end
// Accepts a box and forms the rounded q * coordinate products of both corners.
// ----------------------------------------------------------------------------
module qar_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  qar_pkg::quat_t quat_i,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  qar_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output qar_pkg::mid_t  out_data_o
);
  import qar_pkg::*;

  logic  valid_q;
  logic  en;
  mid_t  data_d;
  mid_t  data_q;

  assign en          = !valid_q || out_ready_i;
  assign in_stall_o  = !en;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_comb begin
    data_d           = '0;
    data_d.lo[0]     = in_data_i.in_min_x;
    data_d.lo[1]     = in_data_i.in_min_y;
    data_d.lo[2]     = in_data_i.in_min_z;
    data_d.hi[0]     = in_data_i.in_max_x;
    data_d.hi[1]     = in_data_i.in_max_y;
    data_d.hi[2]     = in_data_i.in_max_z;
    data_d.box_valid = in_data_i.in_box_valid;
    data_d.m_yz[0]   = mulq1(quat_i.y, in_data_i.in_min_z);
    data_d.m_yz[1]   = mulq1(quat_i.y, in_data_i.in_max_z);
    data_d.m_zy[0]   = mulq1(quat_i.z, in_data_i.in_min_y);
    data_d.m_zy[1]   = mulq1(quat_i.z, in_data_i.in_max_y);
    data_d.m_zx[0]   = mulq1(quat_i.z, in_data_i.in_min_x);
    data_d.m_zx[1]   = mulq1(quat_i.z, in_data_i.in_max_x);
    data_d.m_xz[0]   = mulq1(quat_i.x, in_data_i.in_min_z);
    data_d.m_xz[1]   = mulq1(quat_i.x, in_data_i.in_max_z);
    data_d.m_xy[0]   = mulq1(quat_i.x, in_data_i.in_min_y);
    data_d.m_xy[1]   = mulq1(quat_i.x, in_data_i.in_max_y);
    data_d.m_yx[0]   = mulq1(quat_i.y, in_data_i.in_min_x);
    data_d.m_yx[1]   = mulq1(quat_i.y, in_data_i.in_max_x);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && in_valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

FILE: rtl/core/qar_fifo.sv
// ----------------------------------------------------------------------------
// Quaternion AABB rotate queue
// Two-entry queue between the front end and the rotation pipeline.
// ----------------------------------------------------------------------------
module qar_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  qar_pkg::mid_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output qar_pkg::mid_t out_data_o
);
  import qar_pkg::*;

  mid_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              push, pop;

  assign in_ready_o  = (cnt_q != QCNT_W'(QUEUE_DEPTH));
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
      end
      if (pop) begin
        rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_data_i;
    end
  end

endmodule

FILE: rtl/core/qar_back.sv
// ----------------------------------------------------------------------------
// Quaternion AABB rotate back end
// Rotates the eight corners and reduces them to the new per-axis bounds.
// ----------------------------------------------------------------------------
module qar_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  qar_pkg::quat_t quat_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  qar_pkg::mid_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output qar_pkg::out_t  out_data_o
);
  import qar_pkg::*;

  logic v0_q, v1_q, v2_q, v3_q, v4_q;
  logic en0, en1, en2, en3, en4;

  logic signed [COORD_BITS-1:0] lo0_q [NUM_AXES];
  logic signed [COORD_BITS-1:0] hi0_q [NUM_AXES];
  logic signed [COORD_BITS-1:0] lo1_q [NUM_AXES];
  logic signed [COORD_BITS-1:0] hi1_q [NUM_AXES];
  logic bv0_q, bv1_q, bv2_q, bv3_q;

  logic signed [U_W-1:0]        u_d  [NUM_CORNERS][NUM_AXES];
  logic signed [U_W-1:0]        u_q  [NUM_CORNERS][NUM_AXES];
  logic signed [T_W-1:0]        t_d  [NUM_CORNERS][NUM_AXES];
  logic signed [T_W-1:0]        t_q  [NUM_CORNERS][NUM_AXES];
  logic signed [M2_W-1:0]       wu_d [NUM_CORNERS][NUM_AXES];
  logic signed [M2_W-1:0]       wu_q [NUM_CORNERS][NUM_AXES];
  logic signed [COORD_BITS-1:0] r_d  [NUM_CORNERS][NUM_AXES];
  logic signed [COORD_BITS-1:0] r_q  [NUM_CORNERS][NUM_AXES];
  logic signed [COORD_BITS-1:0] mn_d [NUM_AXES][2];
  logic signed [COORD_BITS-1:0] mn_q [NUM_AXES][2];
  logic signed [COORD_BITS-1:0] mx_d [NUM_AXES][2];
  logic signed [COORD_BITS-1:0] mx_q [NUM_AXES][2];
  out_t                         out_d, out_q;

  assign en4         = !v4_q || !out_stall_i;
  assign en3         = !v3_q || en4;
  assign en2         = !v2_q || en3;
  assign en1         = !v1_q || en2;
  assign en0         = !v0_q || en1;
  assign in_ready_o  = en0;
  assign out_valid_o = v4_q;
  assign out_data_o  = out_q;

  // stage 0: first cross product per corner, corner bits are x:y:z
  always_comb begin
    for (int c = 0; c < NUM_CORNERS; c++) begin
      u_d[c][0] = U_W'($signed(in_data_i.m_yz[c[0]])) - U_W'($signed(in_data_i.m_zy[c[1]]));
      u_d[c][1] = U_W'($signed(in_data_i.m_zx[c[2]])) - U_W'($signed(in_data_i.m_xz[c[0]]));
      u_d[c][2] = U_W'($signed(in_data_i.m_xy[c[1]])) - U_W'($signed(in_data_i.m_yx[c[2]]));
    end
  end

  // stage 1: second cross product and w * u
  always_comb begin
    for (int c = 0; c < NUM_CORNERS; c++) begin
      t_d[c][0]  = T_W'(mulq2(quat_i.y, u_q[c][2])) - T_W'(mulq2(quat_i.z, u_q[c][1]));
      t_d[c][1]  = T_W'(mulq2(quat_i.z, u_q[c][0])) - T_W'(mulq2(quat_i.x, u_q[c][2]));
      t_d[c][2]  = T_W'(mulq2(quat_i.x, u_q[c][1])) - T_W'(mulq2(quat_i.y, u_q[c][0]));
      for (int k = 0; k < NUM_AXES; k++) begin
        wu_d[c][k] = mulq2(quat_i.w, u_q[c][k]);
      end
    end
  end

  // stage 2: p + 2 * (w*u + t), saturated
  always_comb begin
    logic signed [COORD_BITS-1:0] p;
    for (int c = 0; c < NUM_CORNERS; c++) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        p = c[2 - k] ? hi1_q[k] : lo1_q[k];
        r_d[c][k] = sat_coord(R_W'(p) + ((R_W'(wu_q[c][k]) + R_W'(t_q[c][k])) <<< 1));
      end
    end
  end

  // stage 3: eight corners down to two per axis
  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      for (int h = 0; h < 2; h++) begin
        mn_d[k][h] = min2(min2(r_q[4*h][k], r_q[4*h+1][k]), min2(r_q[4*h+2][k], r_q[4*h+3][k]));
        mx_d[k][h] = max2(max2(r_q[4*h][k], r_q[4*h+1][k]), max2(r_q[4*h+2][k], r_q[4*h+3][k]));
      end
    end
  end

  always_comb begin
    out_d.out_min_x     = min2(mn_q[0][0], mn_q[0][1]);
    out_d.out_min_y     = min2(mn_q[1][0], mn_q[1][1]);
    out_d.out_min_z     = min2(mn_q[2][0], mn_q[2][1]);
    out_d.out_max_x     = max2(mx_q[0][0], mx_q[0][1]);
    out_d.out_max_y     = max2(mx_q[1][0], mx_q[1][1]);
    out_d.out_max_z     = max2(mx_q[2][0], mx_q[2][1]);
    out_d.out_box_valid = bv3_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en0) begin
        v0_q <= in_valid_i;
      end
      if (en1) begin
        v1_q <= v0_q;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
      if (en4) begin
        v4_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en0 && in_valid_i) begin
      u_q   <= u_d;
      bv0_q <= in_data_i.box_valid;
      for (int k = 0; k < NUM_AXES; k++) begin
        lo0_q[k] <= $signed(in_data_i.lo[k]);
        hi0_q[k] <= $signed(in_data_i.hi[k]);
      end
    end
    if (en1 && v0_q) begin
      t_q   <= t_d;
      wu_q  <= wu_d;
      lo1_q <= lo0_q;
      hi1_q <= hi0_q;
      bv1_q <= bv0_q;
    end
    if (en2 && v1_q) begin
      r_q   <= r_d;
      bv2_q <= bv1_q;
    end
    if (en3 && v2_q) begin
      mn_q  <= mn_d;
      mx_q  <= mx_d;
      bv3_q <= bv2_q;
    end
    if (en4 && v3_q) begin
      out_q <= out_d;
    end
  end

endmodule

FILE: rtl/core/quaternion_aabb_rotate_top.sv
// ----------------------------------------------------------------------------
// Quaternion AABB rotate
// Rotates an axis-aligned box by a unit quaternion and returns its new bounds.
//
//   channel   direction  handshake              payload
//   in        request    in_valid_i/in_stall_o  in_data_i  (in_t)
//   out       result     out_valid_o/out_stall_i out_data_o (out_t)
//   cfg       write      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One request per cycle sustained while out_stall_i is low; after acceptance a
// request passes the front product stage, the queue and five back stages.
// Reset clears all valid state and sets the quaternion to identity.
// The two-entry queue lets the front keep accepting while the back is stalled.
// Config is taken every cycle; cfg_ready_o is always high.
// ----------------------------------------------------------------------------
`include "quaternion_aabb_rotate_top_macros.svh"

module quaternion_aabb_rotate_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  qar_pkg::in_t                      in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output qar_pkg::out_t                     out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [qar_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [qar_pkg::QUAT_BITS-1:0]     cfg_data_i
);
  import qar_pkg::*;

  localparam int unsigned CAPACITY = 1 + QUEUE_DEPTH + 5;
  localparam int unsigned CAP_W    = $clog2(CAPACITY + 1);

  quat_t            quat_q;
  mid_t             f_data, q_data;
  logic             f_valid, f_ready, q_valid, q_ready;
  logic [CAP_W-1:0] inflight_q;
  logic             in_acc, out_acc;

  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quat_q.w <= QUAT_BITS'(1) << QUAT_FRAC_BITS;
      quat_q.x <= '0;
      quat_q.y <= '0;
      quat_q.z <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_QUAT_W: quat_q.w <= cfg_data_i;
        REG_QUAT_X: quat_q.x <= cfg_data_i;
        REG_QUAT_Y: quat_q.y <= cfg_data_i;
        REG_QUAT_Z: quat_q.z <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else if (in_acc && !out_acc) begin
      inflight_q <= inflight_q + CAP_W'(1);
    end else if (out_acc && !in_acc) begin
      inflight_q <= inflight_q - CAP_W'(1);
    end
  end

  qar_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .quat_i      (quat_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (f_valid),
    .out_ready_i (f_ready),
    .out_data_o  (f_data)
  );

  qar_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (f_valid),
    .in_ready_o  (f_ready),
    .in_data_i   (f_data),
    .out_valid_o (q_valid),
    .out_ready_i (q_ready),
    .out_data_o  (q_data)
  );

  qar_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .quat_i      (quat_q),
    .in_valid_i  (q_valid),
    .in_ready_o  (q_ready),
    .in_data_i   (q_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  `QAR_ASSERT_NOW(a_cap, clk_i, rst_ni, 1'b1, inflight_q <= CAP_W'(CAPACITY), "too many requests in flight")
  `QAR_ASSERT_NOW(a_no_phantom, clk_i, rst_ni, out_valid_o, inflight_q != '0, "result without request")
  `QAR_ASSERT_NEXT(a_cfg_w, clk_i, rst_ni, cfg_valid_i && cfg_index_i == REG_QUAT_W, quat_q.w == $past(cfg_data_i), "quat_w write lost")

endmodule

FILE: bench/tb_quaternion_aabb_rotate_top.sv
// ----------------------------------------------------------------------------
// Quaternion AABB rotate testbench
// Streams boxes through the rotator under several quaternion settings and
// handshake idling phases. Each returned box is compared with its given bounds
// or with a local fixed-point model of the corner rotation and per-axis min/max.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_quaternion_aabb_rotate_top;
  import qar_pkg::*;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  in_t                  in_data_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  out_t                 out_data_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [QUAT_BITS-1:0] cfg_data_i = '0;

  quaternion_aabb_rotate_top dut (.*);

  always #5 clk_i = ~clk_i;

  typedef struct {
    in_t  box;
    bit   typed;
    out_t bounds;
  } box_row_t;

  out_t        bounds_q[$];
  quat_t       rot_q;
  int          errors = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  bit          hold_off = 1'b0;

  localparam logic signed [QUAT_BITS-1:0] ONE = 18'sd65536;
  localparam logic signed [QUAT_BITS-1:0] R45 = 18'sd46341;

  function automatic longint scale_q(longint q, longint v);
    return (q * v + 64'sd32768) >>> QUAT_FRAC_BITS;
  endfunction

  function automatic out_t rotate_bounds(quat_t q, in_t b);
    longint qw, qx, qy, qz, lo[3], hi[3], p[3], u[3], t[3], r, mn[3], mx[3];
    out_t o;
    qw = longint'(q.w); qx = longint'(q.x); qy = longint'(q.y); qz = longint'(q.z);
    lo[0] = longint'(b.in_min_x); lo[1] = longint'(b.in_min_y); lo[2] = longint'(b.in_min_z);
    hi[0] = longint'(b.in_max_x); hi[1] = longint'(b.in_max_y); hi[2] = longint'(b.in_max_z);
    for (int c = 0; c < 8; c++) begin
      p[0] = c[2] ? hi[0] : lo[0];
      p[1] = c[1] ? hi[1] : lo[1];
      p[2] = c[0] ? hi[2] : lo[2];
      u[0] = scale_q(qy, p[2]) - scale_q(qz, p[1]);
      u[1] = scale_q(qz, p[0]) - scale_q(qx, p[2]);
      u[2] = scale_q(qx, p[1]) - scale_q(qy, p[0]);
      t[0] = scale_q(qy, u[2]) - scale_q(qz, u[1]);
      t[1] = scale_q(qz, u[0]) - scale_q(qx, u[2]);
      t[2] = scale_q(qx, u[1]) - scale_q(qy, u[0]);
      for (int k = 0; k < 3; k++) begin
        r = p[k] + 2 * (scale_q(qw, u[k]) + t[k]);
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        if (c == 0 || r < mn[k]) mn[k] = r;
        if (c == 0 || r > mx[k]) mx[k] = r;
      end
    end
    o.out_min_x = 32'(mn[0]); o.out_min_y = 32'(mn[1]); o.out_min_z = 32'(mn[2]);
    o.out_max_x = 32'(mx[0]); o.out_max_y = 32'(mx[1]); o.out_max_z = 32'(mx[2]);
    o.out_box_valid = b.in_box_valid;
    return o;
  endfunction

  task automatic report_mismatch(string what);
    $display("%0t ERROR %s", $realtime, what);
    errors++;
  endtask

  always @(posedge clk_i) begin
    out_t want;
    out_stall_i <= hold_off || ($urandom_range(99) < stall_pct);
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (bounds_q.size() == 0) begin
        report_mismatch("box bounds with no request outstanding");
      end else begin
        want = bounds_q.pop_front();
        if (out_data_o.out_min_x !== want.out_min_x)
          report_mismatch($sformatf("min_x %h exp %h", out_data_o.out_min_x, want.out_min_x));
        if (out_data_o.out_min_y !== want.out_min_y)
          report_mismatch($sformatf("min_y %h exp %h", out_data_o.out_min_y, want.out_min_y));
        if (out_data_o.out_min_z !== want.out_min_z)
          report_mismatch($sformatf("min_z %h exp %h", out_data_o.out_min_z, want.out_min_z));
        if (out_data_o.out_max_x !== want.out_max_x)
          report_mismatch($sformatf("max_x %h exp %h", out_data_o.out_max_x, want.out_max_x));
        if (out_data_o.out_max_y !== want.out_max_y)
          report_mismatch($sformatf("max_y %h exp %h", out_data_o.out_max_y, want.out_max_y));
        if (out_data_o.out_max_z !== want.out_max_z)
          report_mismatch($sformatf("max_z %h exp %h", out_data_o.out_max_z, want.out_max_z));
        if (out_data_o.out_box_valid !== want.out_box_valid)
          report_mismatch("box_valid flag");
      end
    end
  end

  task automatic send_box(in_t b, bit typed, out_t bounds);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    bounds_q.push_back(typed ? bounds : rotate_bounds(rot_q, b));
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [QUAT_BITS-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_QUAT_W: rot_q.w = val;
      REG_QUAT_X: rot_q.x = val;
      REG_QUAT_Y: rot_q.y = val;
      REG_QUAT_Z: rot_q.z = val;
      default: ;
    endcase
  endtask

  task automatic set_quat(logic [QUAT_BITS-1:0] w, logic [QUAT_BITS-1:0] x,
                          logic [QUAT_BITS-1:0] y, logic [QUAT_BITS-1:0] z);
    write_reg(REG_QUAT_W, w);
    write_reg(REG_QUAT_X, x);
    write_reg(REG_QUAT_Y, y);
    write_reg(REG_QUAT_Z, z);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (bounds_q.size() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return 32'(signed'($urandom_range(2000000)) - 1000000);
    endcase
  endfunction

  function automatic in_t rand_box();
    in_t b;
    logic signed [31:0] a, c;
    logic [31:0] v[3];
    for (int k = 0; k < 3; k++) v[k] = rand_coord();
    b.in_min_x = v[0]; b.in_min_y = v[1]; b.in_min_z = v[2];
    b.in_max_x = rand_coord(); b.in_max_y = rand_coord(); b.in_max_z = rand_coord();
    if ($urandom_range(3) != 0) begin
      a = b.in_min_x; c = b.in_max_x;
      if (a > c) begin b.in_min_x = c; b.in_max_x = a; end
      a = b.in_min_y; c = b.in_max_y;
      if (a > c) begin b.in_min_y = c; b.in_max_y = a; end
      a = b.in_min_z; c = b.in_max_z;
      if (a > c) begin b.in_min_z = c; b.in_max_z = a; end
    end
    b.in_box_valid = ($urandom_range(7) != 0);
    return b;
  endfunction

  function automatic logic [QUAT_BITS-1:0] rand_part();
    case ($urandom_range(3))
      0: return QUAT_BITS'($urandom);
      default: return QUAT_BITS'(signed'($urandom_range(131072)) - 65536);
    endcase
  endfunction

  function automatic box_row_t mk_row(logic [31:0] x0, logic [31:0] y0, logic [31:0] z0,
                                      logic [31:0] x1, logic [31:0] y1, logic [31:0] z1,
                                      bit vld, bit typed,
                                      logic [31:0] ex0, logic [31:0] ey0, logic [31:0] ez0,
                                      logic [31:0] ex1, logic [31:0] ey1, logic [31:0] ez1);
    box_row_t r;
    r.box = {x0, y0, z0, x1, y1, z1, vld};
    r.typed = typed;
    r.bounds = {ex0, ey0, ez0, ex1, ey1, ez1, vld};
    return r;
  endfunction

  box_row_t ident_rows[$];
  box_row_t turn_rows[$];

  initial begin
    int unsigned phase_idle[6] = '{0, 77, 0, 77, 9, 0};
    int unsigned phase_stall[6] = '{0, 0, 77, 77, 9, 0};
    rot_q = '{w: ONE, x: 0, y: 0, z: 0};
    // identity quaternion: bounds equal the corners, min/max reordered per axis
    ident_rows.push_back(mk_row(0, 0, 0, 32'h10000, 32'h20000, 32'h30000, 1, 1,
                                0, 0, 0, 32'h10000, 32'h20000, 32'h30000));
    ident_rows.push_back(mk_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1, 1,
                                32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    ident_rows.push_back(mk_row(5, 6, 7, 1, 2, 3, 0, 1, 1, 2, 3, 5, 6, 7));
    ident_rows.push_back(mk_row(32'hffff_ffff, 32'hffff_0000, 0, 1, 32'h0001_0000, 0, 0, 1,
                                32'hffff_ffff, 32'hffff_0000, 0, 1, 32'h0001_0000, 0));
    turn_rows.push_back(mk_row(0, 0, 0, 32'h10000, 32'h10000, 32'h10000, 1, 0,
                               0, 0, 0, 0, 0, 0));
    turn_rows.push_back(mk_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                               32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1, 0,
                               0, 0, 0, 0, 0, 0));
    turn_rows.push_back(mk_row(32'h0040_0000, 32'hfff0_0000, 32'h1234_5678,
                               32'hffc0_0000, 32'h0010_0000, 32'hedcb_a988, 0, 0,
                               0, 0, 0, 0, 0, 0));
    turn_rows.push_back(mk_row(32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
                               32'h5555_5556, 32'haaaa_aaab, 32'h5555_5556, 1, 0,
                               0, 0, 0, 0, 0, 0));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (ident_rows[i]) send_box(ident_rows[i].box, 1'b1, ident_rows[i].bounds);
    drain();
    // quarter turns about each axis, extremes, non-unit, and ignored indexes
    for (int s = 0; s < 6; s++) begin
      case (s)
        0: set_quat(R45, R45, 0, 0);
        1: set_quat(R45, 0, R45, 0);
        2: set_quat(R45, 0, 0, R45);
        3: set_quat(-ONE, -ONE, ONE, -ONE);
        4: set_quat(18'h1ffff, 18'h20000, 18'h2aaaa, 18'h15555);
        default: begin
          write_reg(8'd4, 18'h3ffff);
          write_reg(8'hff, 18'h12345);
          cfg_valid_i <= 1'b0;
        end
      endcase
      foreach (turn_rows[i]) send_box(turn_rows[i].box, 1'b0, turn_rows[i].bounds);
      drain();
    end

    for (int ph = 0; ph < 6; ph++) begin
      idle_pct  = phase_idle[ph];
      stall_pct = phase_stall[ph];
      case (ph)
        0: set_quat(ONE, 0, 0, 0);
        1: set_quat(0, ONE, 0, 0);
        2: set_quat(R45, 18'sd23170, -18'sd23170, 18'sd32768);
        default: set_quat(rand_part(), rand_part(), rand_part(), rand_part());
      endcase
      if (ph == 5) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (60) @(posedge clk_i);
            hold_off = 1'b0;
          end
        join_none
      end
      repeat (75) send_box(rand_box(), 1'b0, '0);
      drain();
    end

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
